>>> rtl/vic_pkg.sv
// Shared types, register offsets and identification bytes of the vectored interrupt controller.
package vic_pkg;

   typedef enum logic [1:0] {
      MODE_READ    = 2'd0,
      MODE_WRITE   = 2'd1,
      MODE_ASSERT  = 2'd2,
      MODE_RESCIND = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
      logic [4:0]  line_number;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_ok;
      logic        irq_out;
      logic        fiq_out;
   } rsp_type;

   localparam logic [11:0] REG_IRQ_STATUS = 12'h000;
   localparam logic [11:0] REG_FIQ_STATUS = 12'h004;
   localparam logic [11:0] REG_RAW_STATUS = 12'h008;
   localparam logic [11:0] REG_SELECT     = 12'h00C;
   localparam logic [11:0] REG_ENABLE     = 12'h010;
   localparam logic [11:0] REG_ENABLE_CLR = 12'h014;
   localparam logic [11:0] REG_SOFT       = 12'h018;
   localparam logic [11:0] REG_SOFT_CLR   = 12'h01C;
   localparam logic [11:0] REG_VECT_ADDR  = 12'h030;
   localparam logic [11:0] REG_DEF_VECT   = 12'h034;
   localparam logic [11:0] REG_ID_BASE    = 12'hFE0;

   localparam logic [3:0] PAGE_LOW       = 4'h0;
   localparam logic [3:0] PAGE_VECT_ADDR = 4'h1;
   localparam logic [3:0] PAGE_VECT_CTRL = 4'h2;

   localparam int VECT_CTRL_EN_BIT = 5;

   function automatic logic [7:0] id_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h90;
         3'd1: b = 8'h11;
         3'd2: b = 8'h04;
         3'd3: b = 8'h00;
         3'd4: b = 8'h0D;
         3'd5: b = 8'hF0;
         3'd6: b = 8'h05;
         3'd7: b = 8'hB1;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/vectored_interrupt_controller_unit.sv
// Vectored interrupt controller: register file, priority stack and IRQ/FIQ generation.
//
//   channel  | ports                          | direction | moves
//   ---------+--------------------------------+-----------+-----------------------------
//   request  | req_valid req_ready req_data   | in        | bus read/write or line change
//   response | rsp_valid rsp_ready rsp_data   | out       | read data, ok, IRQ, FIQ
//
// A request is registered, then processed against the register state as its response
// is registered, so one request per cycle is sustained while responses are taken.
// The priority encoder over the vector controls lies on the path between the two registers.
// Reset clears valid flags, control registers, vector valid bits; sets the lowest priority.
// A stalled response holds the input register; req_ready drops only while both are full.
module vectored_interrupt_controller_unit
   import vic_pkg::*;
#(
   parameter int NUM_VECTORS = 16,
   parameter int NUM_LINES   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int Lowest = NUM_VECTORS + 1;
   localparam int PrioW  = $clog2(NUM_VECTORS + 2);
   localparam int IdxW   = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
   localparam int SavW   = $clog2(NUM_VECTORS + 1);
   localparam logic [31:0] LineMask = 32'hFFFF_FFFF >> (32 - NUM_LINES);
   localparam logic [PrioW-1:0] LowestP = PrioW'(Lowest);
   localparam logic [PrioW-1:0] NumVecP = PrioW'(NUM_VECTORS);
   localparam logic [PrioW-1:0] ModP    = PrioW'(Lowest + 1);

   // Input register and handshake
   logic    in_valid_ff;
   req_type in_ff;
   logic    fire;

   // Register state
   logic [31:0]      raw_ff, raw_in;
   logic [31:0]      soft_ff, soft_in;
   logic [31:0]      enable_ff, enable_in;
   logic [31:0]      select_ff, select_in;
   logic [31:0]      defvec_ff, defvec_in;
   logic [31:0]      vc_ff [NUM_VECTORS];
   logic [31:0]      vc_in [NUM_VECTORS];
   logic [PrioW-1:0] cp_ff, cp_in;
   logic [PrioW-1:0] saved_ff [NUM_VECTORS + 1];

   logic             sav_we;
   logic [SavW-1:0]  sav_wa;
   logic [PrioW-1:0] sav_wd;

   // Vector address memory with per-entry valid bits
   logic [31:0]         va_mem [NUM_VECTORS];
   logic                va_vld_ff [NUM_VECTORS];
   logic                va_we;
   logic [IdxW-1:0]     va_wa;
   logic [IdxW-1:0]     va_ra;
   logic                va_re;
   logic [31:0]         va_rd_ff;
   logic                va_rd_vld_ff;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    use_va_ff, use_va_in;

   // Decode and next-state scratch
   logic [31:0]           pend;
   logic [NUM_VECTORS-1:0] vec_hit;
   logic [PrioW-1:0]      first_prio;
   logic [PrioW-1:0]      sel_prio;
   logic [PrioW-1:0]      sav_rd;
   logic [11:0]           off;
   logic [5:0]            widx;
   logic                  vec_ok;
   logic [IdxW-1:0]       vidx;
   logic [31:0]           pmask;
   logic [31:0]           pend_in;
   logic [31:0]           act_irq;
   logic [31:0]           act_fiq;
   logic [31:0]           line_bit;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data = rsp_ff;
      if (use_va_ff) begin
         rsp_data.read_data = va_rd_vld_ff ? va_rd_ff : 32'h0;
      end
   end

   always_comb begin
      raw_in    = raw_ff;
      soft_in   = soft_ff;
      enable_in = enable_ff;
      select_in = select_ff;
      defvec_in = defvec_ff;
      cp_in     = cp_ff;
      for (int j = 0; j < NUM_VECTORS; j++) begin
         vc_in[j] = vc_ff[j];
      end
      sav_we    = 1'b0;
      sav_wa    = '0;
      sav_wd    = cp_ff;
      va_we     = 1'b0;
      va_wa     = '0;
      va_re     = 1'b0;
      va_ra     = '0;
      use_va_in = 1'b0;
      rsp_in    = '0;

      pend = (raw_ff | soft_ff) & LineMask;

      // Highest-priority enabled vector whose source is pending
      for (int j = 0; j < NUM_VECTORS; j++) begin
         vec_hit[j] = vc_ff[j][VECT_CTRL_EN_BIT] && pend[vc_ff[j][4:0]];
      end
      first_prio = (pend != 32'h0) ? NumVecP : LowestP;
      for (int j = NUM_VECTORS - 1; j >= 0; j--) begin
         if (vec_hit[j]) begin
            first_prio = PrioW'(j);
         end
      end
      sel_prio = (first_prio < cp_ff) ? first_prio : cp_ff;

      sav_rd = saved_ff[cp_ff[SavW-1:0]];

      off      = in_ff.reg_offset;
      widx     = off[7:2];
      vec_ok   = int'(widx) < NUM_VECTORS;
      vidx     = widx[IdxW-1:0];
      line_bit = 32'h1 << in_ff.line_number;

      case (in_ff.mode)
         MODE_READ: begin
            if (off[11:8] == PAGE_LOW) begin
               rsp_in.access_ok = 1'b1;
               case (off)
                  REG_IRQ_STATUS: rsp_in.read_data = pend & enable_ff & ~select_ff;
                  REG_FIQ_STATUS: rsp_in.read_data = pend & enable_ff & select_ff;
                  REG_RAW_STATUS: rsp_in.read_data = pend;
                  REG_SELECT:     rsp_in.read_data = select_ff;
                  REG_ENABLE:     rsp_in.read_data = enable_ff;
                  REG_SOFT:       rsp_in.read_data = soft_ff;
                  REG_DEF_VECT:   rsp_in.read_data = defvec_ff;
                  REG_VECT_ADDR: begin
                     // Acknowledge: raise priority to the winning vector and push the old one.
                     if (sel_prio < cp_ff) begin
                        sav_we = 1'b1;
                        sav_wa = sel_prio[SavW-1:0];
                        cp_in  = sel_prio;
                     end
                     if (sel_prio != LowestP && cp_in < NumVecP) begin
                        use_va_in = 1'b1;
                        va_re     = 1'b1;
                        va_ra     = cp_in[IdxW-1:0];
                     end else begin
                        rsp_in.read_data = defvec_ff;
                     end
                  end
                  default: rsp_in.access_ok = 1'b0;
               endcase
            end else if (off[11:8] == PAGE_VECT_ADDR) begin
               if (vec_ok) begin
                  rsp_in.access_ok = 1'b1;
                  use_va_in        = 1'b1;
                  va_re            = 1'b1;
                  va_ra            = vidx;
               end
            end else if (off[11:8] == PAGE_VECT_CTRL) begin
               if (vec_ok) begin
                  rsp_in.access_ok = 1'b1;
                  rsp_in.read_data = vc_ff[vidx];
               end
            end else if (off >= REG_ID_BASE) begin
               rsp_in.access_ok = 1'b1;
               if (off[1:0] == 2'b00) begin
                  rsp_in.read_data = {24'h0, id_byte(off[4:2])};
               end
            end
         end
         MODE_WRITE: begin
            if (off[11:8] == PAGE_LOW) begin
               rsp_in.access_ok = 1'b1;
               case (off)
                  REG_SELECT:     select_in = in_ff.write_data & LineMask;
                  REG_ENABLE:     enable_in = (enable_ff | in_ff.write_data) & LineMask;
                  REG_ENABLE_CLR: enable_in = enable_ff & ~in_ff.write_data;
                  REG_SOFT:       soft_in   = (soft_ff | in_ff.write_data) & LineMask;
                  REG_SOFT_CLR:   soft_in   = soft_ff & ~in_ff.write_data;
                  REG_DEF_VECT:   defvec_in = in_ff.write_data;
                  REG_VECT_ADDR: begin
                     // End of service: pop the saved priority.
                     if (cp_ff < LowestP) begin
                        cp_in = (sav_rd > LowestP) ? sav_rd - ModP : sav_rd;
                     end
                  end
                  default: rsp_in.access_ok = 1'b0;
               endcase
            end else if (off[11:8] == PAGE_VECT_ADDR) begin
               if (vec_ok) begin
                  rsp_in.access_ok = 1'b1;
                  va_we            = 1'b1;
                  va_wa            = vidx;
               end
            end else if (off[11:8] == PAGE_VECT_CTRL) begin
               if (vec_ok) begin
                  rsp_in.access_ok = 1'b1;
                  vc_in[vidx]      = in_ff.write_data;
               end
            end
         end
         MODE_ASSERT: begin
            if (int'(in_ff.line_number) < NUM_LINES) begin
               rsp_in.access_ok = 1'b1;
               raw_in           = raw_ff | line_bit;
            end
         end
         MODE_RESCIND: begin
            if (int'(in_ff.line_number) < NUM_LINES) begin
               rsp_in.access_ok = 1'b1;
               raw_in           = raw_ff & ~line_bit;
            end
         end
         default: rsp_in.access_ok = 1'b0;
      endcase

      // Output levels are taken from the state as it stands after this request.
      pmask = 32'h0;
      if (cp_in > NumVecP) begin
         pmask = 32'hFFFF_FFFF;
      end else begin
         for (int j = 0; j < NUM_VECTORS; j++) begin
            if (PrioW'(j) < cp_in && vc_in[j][VECT_CTRL_EN_BIT]) begin
               pmask[vc_in[j][4:0]] = 1'b1;
            end
         end
      end
      pend_in        = (raw_in | soft_in) & LineMask;
      act_irq        = pend_in & enable_in & ~select_in & pmask;
      act_fiq        = pend_in & enable_in & select_in & pmask;
      rsp_in.irq_out = act_irq != 32'h0;
      rsp_in.fiq_out = act_fiq != 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         raw_ff       <= 32'h0;
         soft_ff      <= 32'h0;
         enable_ff    <= 32'h0;
         select_ff    <= 32'h0;
         defvec_ff    <= 32'h0;
         cp_ff        <= LowestP;
         for (int j = 0; j < NUM_VECTORS; j++) begin
            vc_ff[j]     <= 32'h0;
            va_vld_ff[j] <= 1'b0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            raw_ff    <= raw_in;
            soft_ff   <= soft_in;
            enable_ff <= enable_in;
            select_ff <= select_in;
            defvec_ff <= defvec_in;
            cp_ff     <= cp_in;
            for (int j = 0; j < NUM_VECTORS; j++) begin
               vc_ff[j] <= vc_in[j];
            end
            if (va_we) begin
               va_vld_ff[va_wa] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff    <= rsp_in;
         use_va_ff <= use_va_in;
         if (sav_we) begin
            saved_ff[sav_wa] <= sav_wd;
         end
         if (va_we) begin
            va_mem[va_wa] <= in_ff.write_data;
         end
         if (va_re) begin
            va_rd_ff     <= va_mem[va_ra];
            va_rd_vld_ff <= va_vld_ff[va_ra];
         end
      end
   end

endmodule

>>> rtl/vic_checker.sv
// Port-level checker for the vectored interrupt controller, bound to the top level.
module vic_checker
   import vic_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A response that is not taken stays, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or vanished");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response offered straight after reset");

   // A rejected access never returns data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.access_ok |-> rsp_data.read_data == 32'h0)
      else $error("rejected access returned data");

   // Requests are refused only while a response is waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused with the response side free");

endmodule

bind vectored_interrupt_controller_unit vic_checker u_vic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
